FILE: hw/rtl/ray_rectangle_range_macros.svh
// assertion helpers for the range sensor checker
`ifndef RAY_RECTANGLE_RANGE_MACROS_SVH
`define RAY_RECTANGLE_RANGE_MACROS_SVH

// checked only while out of reset
`define RRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rrr_pkg.sv
`timescale 1ns / 1ps
package rrr_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int UNIT_BITS  = 14;
  localparam int UW         = UNIT_BITS + 2;
  localparam int VW         = 50;
  localparam int NW         = 66;
  localparam int PW         = 61;
  localparam int DW         = 30;
  localparam int QW         = 31;
  localparam int SIN_LAT    = 8;
  localparam int GEO_LAT    = 6;
  localparam int MIN_LAT    = 2;

  localparam logic [30:0] QUAD_ONE = 31'd1073741824;
  localparam logic [30:0] SIN_C1   = 31'd1686629713;
  localparam logic [30:0] SIN_C3   = 31'd693598668;
  localparam logic [30:0] SIN_C5   = 31'd85569306;
  localparam logic [30:0] SIN_C7   = 31'd5026996;
  localparam logic [30:0] SIN_C9   = 31'd172272;

  typedef enum logic [2:0] {
    CFG_CORNER_X = 3'd0,
    CFG_CORNER_Y = 3'd1,
    CFG_SIDE_ONE = 3'd2,
    CFG_SIDE_TWO = 3'd3,
    CFG_ROTATION = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] corner_x;
    logic [31:0] corner_y;
    logic [30:0] len1;
    logic [30:0] len2;
  } geom_cfg_t;

  typedef struct packed {
    logic signed [UW-1:0] c;
    logic signed [UW-1:0] s;
    logic signed [UW-1:0] ux;
    logic signed [UW-1:0] uy;
  } unit_set_t;

  typedef struct packed {
    logic          hit;
    logic [PW-1:0] num;
    logic [DW-1:0] den;
  } edge_t;

endpackage

FILE: hw/rtl/ray_rectangle_range.sv
`timescale 1ns / 1ps
// simulated range sensor against one rotated rectangle
// input channel: one ray request per handshake on in_tvalid/in_tready,
//   carrying origin, heading and maximum range
// result channel: out_tdata carries the range, out_tuser the hit flag
// config channel: cfg_valid/cfg_ready with register index and data,
//   always ready; write it only while no ray is in flight
// throughput: one ray per cycle while in_tready is high; every stage advances together
// pipeline: from acceptance to out_tvalid, a ray passes the 8 stage
//   sine polynomial, 6 geometry stages, the 31 stage divider, the
//   2 stage nearest-hit select and the output register
// stall: a skid register behind the pipeline takes one more result
//   while out_tready is low; then in_tready drops until it drains
// reset: rst_n synchronous, clears valids and the config registers
module ray_rectangle_range (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // origin_x, origin_y, heading, max_range
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // range
  output logic         out_tuser,  // hit
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  localparam int QW    = rrr_pkg::QW;
  localparam int SL    = rrr_pkg::SIN_LAT;
  localparam int TOTAL = rrr_pkg::SIN_LAT + rrr_pkg::GEO_LAT + rrr_pkg::QW
                         + rrr_pkg::MIN_LAT;

  // config registers
  logic [31:0] cx_r, cy_r;
  logic [30:0] l1_r, l2_r;
  logic [15:0] rot_r;

  // per-ray side data and stage valids
  logic        vld_r  [1:TOTAL];
  logic [31:0] ox_r   [1:SL];
  logic [31:0] oy_r   [1:SL];
  logic [30:0] rmax_r [1:TOTAL-1];

  // nearest-hit select
  logic [QW-1:0] ba_r, bb_r;
  logic          ha_r, hb_r;
  logic [30:0]   res_range_r;
  logic          res_hit_r;

  // output and skid registers
  logic          out_v_r, skid_v_r;
  logic [30:0]   out_range_r, skid_range_r;
  logic          out_hit_r, skid_hit_r;

  logic               en;
  logic [31:0]        ht, rt;
  logic signed [rrr_pkg::UW-1:0] sin_uy, sin_ux, sin_s, sin_c;
  rrr_pkg::unit_set_t units;
  rrr_pkg::geom_cfg_t gcfg;
  rrr_pkg::edge_t     edges [4];
  logic [QW-1:0]      quo [4];
  logic               hit [4];
  logic [QW-1:0]      best;
  logic               take;

  // wrap the binary angle and widen to a 32 bit turn
  function automatic logic [31:0] to_turn(input logic [15:0] a);
    logic [31:0] m;
    m = {16'b0, a} & ((32'd1 << rrr_pkg::ANGLE_BITS) - 32'd1);
    return m << (32 - rrr_pkg::ANGLE_BITS);
  endfunction

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  assign ht = to_turn(in_tdata[79:64]);
  assign rt = to_turn(rot_r);

  // cosine is the sine a quarter turn ahead
  rrr_sine u_sin_uy (.clk, .en, .turn(ht),                    .unit(sin_uy));
  rrr_sine u_sin_ux (.clk, .en, .turn(ht + 32'h4000_0000),    .unit(sin_ux));
  rrr_sine u_sin_s  (.clk, .en, .turn(rt),                    .unit(sin_s));
  rrr_sine u_sin_c  (.clk, .en, .turn(rt + 32'h4000_0000),    .unit(sin_c));

  always_comb begin
    units.uy      = sin_uy;
    units.ux      = sin_ux;
    units.s       = sin_s;
    units.c       = sin_c;
    gcfg.corner_x = cx_r;
    gcfg.corner_y = cy_r;
    gcfg.len1     = l1_r;
    gcfg.len2     = l2_r;
  end

  rrr_geom u_geom (
    .clk, .en, .cfg(gcfg), .units,
    .ox(ox_r[SL]), .oy(oy_r[SL]), .rmax(rmax_r[SL]),
    .edges_o(edges)
  );

  for (genvar g = 0; g < 4; g++) begin : g_div
    rrr_div u_div (.clk, .en, .edge_i(edges[g]), .quo(quo[g]), .hit(hit[g]));
  end

  assign best = (ha_r && (!hb_r || ba_r <= bb_r)) ? ba_r : bb_r;

  // config writes, indexes past the register list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      l1_r  <= '0;
      l2_r  <= '0;
      rot_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        rrr_pkg::CFG_CORNER_X: cx_r  <= cfg_data;
        rrr_pkg::CFG_CORNER_Y: cy_r  <= cfg_data;
        rrr_pkg::CFG_SIDE_ONE: l1_r  <= cfg_data[30:0];
        rrr_pkg::CFG_SIDE_TWO: l2_r  <= cfg_data[30:0];
        rrr_pkg::CFG_ROTATION: rot_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // valid bits ride alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= TOTAL; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[1] <= in_tvalid;
      for (int i = 2; i <= TOTAL; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // side data and nearest-hit select, no reset needed
  always_ff @(posedge clk) begin
    if (en) begin
      ox_r[1]   <= in_tdata[31:0];
      oy_r[1]   <= in_tdata[63:32];
      rmax_r[1] <= in_tdata[110:80];
      for (int i = 2; i <= SL; i++) begin
        ox_r[i] <= ox_r[i-1];
        oy_r[i] <= oy_r[i-1];
      end
      for (int i = 2; i <= TOTAL - 1; i++) rmax_r[i] <= rmax_r[i-1];

      ba_r <= (hit[0] && (!hit[1] || quo[0] <= quo[1])) ? quo[0] : quo[1];
      ha_r <= hit[0] || hit[1];
      bb_r <= (hit[2] && (!hit[3] || quo[2] <= quo[3])) ? quo[2] : quo[3];
      hb_r <= hit[2] || hit[3];

      // no hit reports the full range
      res_range_r <= (ha_r || hb_r) ? best : rmax_r[TOTAL-1];
      res_hit_r   <= ha_r || hb_r;
    end
  end

  assign take = out_v_r && out_tready;

  // output register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= vld_r[TOTAL];
      end
    end else if (vld_r[TOTAL]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || take) begin
      out_range_r <= skid_v_r ? skid_range_r : res_range_r;
      out_hit_r   <= skid_v_r ? skid_hit_r : res_hit_r;
    end else if (en) begin
      skid_range_r <= res_range_r;
      skid_hit_r   <= res_hit_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_range_r};
  assign out_tuser  = out_hit_r;

endmodule

FILE: hw/rtl/rrr_sine.sv
`timescale 1ns / 1ps
// sine of a 32 bit turn angle to a Q14 unit value, at most one multiply per stage
module rrr_sine (
  input  logic                           clk,
  input  logic                           en,
  input  logic [31:0]                    turn,
  output logic signed [rrr_pkg::UW-1:0]  unit
);

  localparam int UW = rrr_pkg::UW;

  logic [30:0] r_r  [1:6];
  logic [1:0]  q_r  [1:7];
  logic [30:0] x2_r [2:5];
  logic [30:0] p7_r, p5_r, p3_r, p1_r, pr_r;
  logic signed [UW-1:0] unit_r;

  logic [30:0] r_in, pc, rnd;
  logic [14:0] mag;

  function automatic logic [30:0] mul_shift(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] prod;
    prod = 62'(a) * 62'(b);
    return prod[60:30];
  endfunction

  always_comb begin
    r_in = turn[30] ? (rrr_pkg::QUAD_ONE - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};
    pc   = (pr_r > rrr_pkg::QUAD_ONE) ? rrr_pkg::QUAD_ONE : pr_r;
    rnd  = pc + 31'd32768;
    mag  = (rnd[30:16] > 15'd16384) ? 15'd16384 : rnd[30:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[1] <= r_in;
      q_r[1] <= turn[31:30];
      for (int i = 2; i <= 6; i++) r_r[i] <= r_r[i-1];
      for (int i = 2; i <= 7; i++) q_r[i] <= q_r[i-1];
      x2_r[2] <= mul_shift(r_r[1], r_r[1]);
      for (int i = 3; i <= 5; i++) x2_r[i] <= x2_r[i-1];
      p7_r   <= rrr_pkg::SIN_C7 - mul_shift(rrr_pkg::SIN_C9, x2_r[2]);
      p5_r   <= rrr_pkg::SIN_C5 - mul_shift(p7_r, x2_r[3]);
      p3_r   <= rrr_pkg::SIN_C3 - mul_shift(p5_r, x2_r[4]);
      p1_r   <= rrr_pkg::SIN_C1 - mul_shift(p3_r, x2_r[5]);
      pr_r   <= mul_shift(p1_r, r_r[6]);
      unit_r <= q_r[7][1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign unit = unit_r;

endmodule

FILE: hw/rtl/rrr_geom.sv
`timescale 1ns / 1ps
// edge setup: vertices, determinants, numerators and window checks
module rrr_geom (
  input  logic                  clk,
  input  logic                  en,
  input  rrr_pkg::geom_cfg_t    cfg,
  input  rrr_pkg::unit_set_t    units,
  input  logic [31:0]           ox,
  input  logic [31:0]           oy,
  input  logic [30:0]           rmax,
  output rrr_pkg::edge_t        edges_o [4]
);

  localparam int VW = rrr_pkg::VW;
  localparam int NW = rrr_pkg::NW;
  localparam int PW = rrr_pkg::PW;
  localparam int DW = rrr_pkg::DW;
  localparam int UW = rrr_pkg::UW;

  // stage 1
  logic signed [VW-1:0] bx_r, by_r;
  logic signed [47:0]   l1c_r, l1s_r, l2c_r, l2s_r;
  logic signed [31:0]   du0_r, dv0_r, du1_r, dv1_r;
  rrr_pkg::unit_set_t   u1_r, u2_r;
  logic [30:0]          rm_r [1:5];
  // stage 2
  logic signed [VW-1:0] vx_r [4];
  logic signed [VW-1:0] vy_r [4];
  logic signed [31:0]   d2_r [4];
  // stage 3
  logic signed [NW-1:0] a_r [4];
  logic signed [NW-1:0] b_r [4];
  logic signed [NW-1:0] e_r [4];
  logic signed [NW-1:0] f_r [4];
  logic signed [31:0]   d3_r [4];
  // stage 4
  logic signed [NW-1:0] n1_r [4];
  logic signed [NW-1:0] n2_r [4];
  logic signed [31:0]   d4_r [4];
  // stage 5
  logic signed [NW-1:0] n1s_r [4];
  logic signed [NW-1:0] n2s_r [4];
  logic [DW-1:0]        ad_r  [4];
  logic [PW-1:0]        rd_r  [4];
  logic [PW-1:0]        ld_r  [4];
  // stage 6
  rrr_pkg::edge_t       edges_r [4];

  logic signed [32:0]   dx, dy;
  logic signed [31:0]   d0, d1;
  logic signed [UW-1:0] wx [4];
  logic signed [UW-1:0] wy [4];
  logic [30:0]          len [4];
  logic [DW-1:0]        ad  [4];
  logic                 neg [4];
  logic signed [VW-1:0] e1c, e1s, e2c, e2s;

  always_comb begin
    dx  = $signed({cfg.corner_x[31], cfg.corner_x}) - $signed({ox[31], ox});
    dy  = $signed({cfg.corner_y[31], cfg.corner_y}) - $signed({oy[31], oy});
    d0  = du0_r - dv0_r;
    d1  = -du1_r - dv1_r;
    e1c = VW'(l1c_r);
    e1s = VW'(l1s_r);
    e2c = VW'(l2c_r);
    e2s = VW'(l2s_r);
    // edge directions walk the rectangle counterclockwise
    wx[0] = u2_r.c;   wy[0] = u2_r.s;
    wx[1] = -u2_r.s;  wy[1] = u2_r.c;
    wx[2] = -u2_r.c;  wy[2] = -u2_r.s;
    wx[3] = u2_r.s;   wy[3] = -u2_r.c;
    len[0] = cfg.len1; len[1] = cfg.len2; len[2] = cfg.len1; len[3] = cfg.len2;
    for (int i = 0; i < 4; i++) begin
      neg[i] = d4_r[i][31];
      ad[i]  = neg[i] ? DW'(-d4_r[i]) : DW'(d4_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bx_r  <= {{3{dx[32]}}, dx, 14'b0};
      by_r  <= {{3{dy[32]}}, dy, 14'b0};
      l1c_r <= $signed({1'b0, cfg.len1}) * units.c;
      l1s_r <= $signed({1'b0, cfg.len1}) * units.s;
      l2c_r <= $signed({1'b0, cfg.len2}) * units.c;
      l2s_r <= $signed({1'b0, cfg.len2}) * units.s;
      du0_r <= units.uy * units.c;
      dv0_r <= units.ux * units.s;
      du1_r <= units.uy * units.s;
      dv1_r <= units.ux * units.c;
      u1_r  <= units;
      u2_r  <= u1_r;
      rm_r[1] <= rmax;
      for (int i = 2; i <= 5; i++) rm_r[i] <= rm_r[i-1];

      vx_r[0] <= bx_r;                   vy_r[0] <= by_r;
      vx_r[1] <= bx_r + e1c;             vy_r[1] <= by_r + e1s;
      vx_r[2] <= bx_r + e1c - e2s;       vy_r[2] <= by_r + e1s + e2c;
      vx_r[3] <= bx_r - e2s;             vy_r[3] <= by_r + e2c;
      d2_r[0] <= d0;  d2_r[1] <= d1;  d2_r[2] <= -d0;  d2_r[3] <= -d1;

      for (int i = 0; i < 4; i++) begin
        a_r[i]  <= wx[i] * vy_r[i];
        b_r[i]  <= wy[i] * vx_r[i];
        e_r[i]  <= u2_r.ux * vy_r[i];
        f_r[i]  <= u2_r.uy * vx_r[i];
        d3_r[i] <= d2_r[i];

        n1_r[i] <= a_r[i] - b_r[i];
        n2_r[i] <= e_r[i] - f_r[i];
        d4_r[i] <= d3_r[i];

        // flip signs so the determinant is positive
        n1s_r[i] <= neg[i] ? -n1_r[i] : n1_r[i];
        n2s_r[i] <= neg[i] ? -n2_r[i] : n2_r[i];
        ad_r[i]  <= ad[i];
        rd_r[i]  <= PW'(rm_r[4]) * PW'(ad[i]);
        ld_r[i]  <= PW'(len[i]) * PW'(ad[i]);

        edges_r[i].hit <= (ad_r[i] != '0) && (rm_r[5] != '0) && (len[i] != '0)
                          && (n1s_r[i] > 0) && (n1s_r[i] < $signed({5'b0, rd_r[i]}))
                          && (n2s_r[i] > 0) && (n2s_r[i] < $signed({5'b0, ld_r[i]}));
        edges_r[i].num <= n1s_r[i][PW-1:0];
        edges_r[i].den <= ad_r[i];
      end
    end
  end

  assign edges_o = edges_r;

endmodule

FILE: hw/rtl/rrr_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per stage
module rrr_div (
  input  logic                     clk,
  input  logic                     en,
  input  rrr_pkg::edge_t           edge_i,
  output logic [rrr_pkg::QW-1:0]   quo,
  output logic                     hit
);

  localparam int QW = rrr_pkg::QW;
  localparam int PW = rrr_pkg::PW;
  localparam int DW = rrr_pkg::DW;

  logic [PW-1:0] rem_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] den_r [QW];
  logic          hit_r [QW];

  logic [PW-1:0] rem_in  [QW];
  logic [QW-1:0] q_in    [QW];
  logic [DW-1:0] den_in  [QW];
  logic          hit_in  [QW];
  logic [PW-1:0] sh      [QW];
  logic          ge      [QW];

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        rem_in[j] = edge_i.num;
        q_in[j]   = '0;
        den_in[j] = edge_i.den;
        hit_in[j] = edge_i.hit;
      end else begin
        rem_in[j] = rem_r[j-1];
        q_in[j]   = q_r[j-1];
        den_in[j] = den_r[j-1];
        hit_in[j] = hit_r[j-1];
      end
      sh[j] = PW'(den_in[j]) << (QW - 1 - j);
      ge[j] = rem_in[j] >= sh[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        rem_r[j] <= ge[j] ? rem_in[j] - sh[j] : rem_in[j];
        q_r[j]   <= q_in[j] | (QW'(ge[j]) << (QW - 1 - j));
        den_r[j] <= den_in[j];
        hit_r[j] <= hit_in[j];
      end
    end
  end

  assign quo = q_r[QW-1];
  assign hit = hit_r[QW-1];

endmodule

FILE: hw/rtl/rrr_checker.sv
`timescale 1ns / 1ps
`include "ray_rectangle_range_macros.svh"
// port-level checks on the range sensor
module rrr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  logic stall;

  // result offered but not taken
  assign stall = out_tvalid && !out_tready;

  // nothing comes out right after reset
  `RRR_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "result valid after reset")

  // a stalled result holds
  `RRR_ASSERT(a_hold, stall |=> out_tvalid && $stable({out_tdata, out_tuser}), "result changed")

  // input backpressure only while a result is waiting
  `RRR_ASSERT(a_bp_cause, !in_tready |-> out_tvalid, "input stalled with no result pending")

  // input stalls only after the receiver stalled
  `RRR_ASSERT(a_bp_start, $fell(in_tready) |-> $past(stall), "input stalled without output stall")

endmodule

bind ray_rectangle_range rrr_checker u_rrr_checker (.*);
